@@ hw/rtl/matrix3_inverse_adjugate_macros.svh @@
// Assertion macros for the 3x3 matrix inverse block.
// Used by the top level only; each macro needs clk and rst_n in scope.
`ifndef MATRIX3_INVERSE_ADJUGATE_MACROS_SVH
`define MATRIX3_INVERSE_ADJUGATE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MI3_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MI3_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mi3_pkg.sv @@
// Shared types and constants for the 3x3 matrix inverse block.
// No dependencies.
package mi3_pkg;

    localparam int NUM_ELEM = 9;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_SINGULAR  = 2'd1;
    localparam status_t ST_SATURATED = 2'd2;

    // Column-major element index.
    typedef logic [3:0] idx_t;

    // Adjugate entry k is m[COF_A]*m[COF_B] - m[COF_C]*m[COF_D].
    localparam idx_t COF_A [NUM_ELEM] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
    localparam idx_t COF_B [NUM_ELEM] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
    localparam idx_t COF_C [NUM_ELEM] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
    localparam idx_t COF_D [NUM_ELEM] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

    // Elements of the first row, used for the determinant expansion.
    localparam idx_t ROW0 [3] = '{4'd0, 4'd3, 4'd6};

endpackage

@@ hw/rtl/mi3_adj.sv @@
// Adjugate and determinant pipeline, four stages.
// Depends on mi3_pkg.
module mi3_adj #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                          clk,
    input  logic signed [ELEM_WIDTH-1:0]  m   [9],
    output logic signed [2*ELEM_WIDTH:0]  adj [9],
    output logic signed [3*ELEM_WIDTH+1:0] det
);
    import mi3_pkg::*;

    localparam int EW = ELEM_WIDTH;
    localparam int PW = 2 * EW;
    localparam int AW = PW + 1;
    localparam int H  = EW + 1;
    localparam int DW = 3 * EW + 2;
    localparam int LW = EW + H + 1;

    logic signed [PW-1:0] pa_reg     [NUM_ELEM];
    logic signed [PW-1:0] pb_reg     [NUM_ELEM];
    logic signed [EW-1:0] mt1_reg    [3];
    logic signed [EW-1:0] mt2_reg    [3];
    logic signed [AW-1:0] adj_s2_reg [NUM_ELEM];
    logic signed [AW-1:0] adj_s3_reg [NUM_ELEM];
    logic signed [AW-1:0] adj_reg    [NUM_ELEM];
    logic signed [LW-1:0] plo_reg    [3];
    logic signed [PW-1:0] phi_reg    [3];
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;

    // Stage 1: the two products of every cofactor.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            pa_reg[k] <= m[COF_A[k]] * m[COF_B[k]];
            pb_reg[k] <= m[COF_C[k]] * m[COF_D[k]];
        end
        for (int j = 0; j < 3; j++)
        begin
            mt1_reg[j] <= m[ROW0[j]];
        end
    end

    // Stage 2: cofactor differences, exact at one bit over the product width.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            adj_s2_reg[k] <= {pa_reg[k][PW-1], pa_reg[k]} - {pb_reg[k][PW-1], pb_reg[k]};
        end
        mt2_reg <= mt1_reg;
    end

    // Stage 3: first-row products, each split into a high and a low partial product.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            plo_reg[j] <= mt2_reg[j] * $signed({1'b0, adj_s2_reg[j][H-1:0]});
            phi_reg[j] <= mt2_reg[j] * $signed(adj_s2_reg[j][AW-1:H]);
        end
        adj_s3_reg <= adj_s2_reg;
    end

    // Stage 4: recombine the partial products into the determinant.
    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (DW'(phi_reg[j]) <<< H) + DW'(plo_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg <= det_next;
        adj_reg <= adj_s3_reg;
    end

    assign adj = adj_reg;
    assign det = det_reg;

endmodule

@@ hw/rtl/mi3_lane.sv @@
// One divider lane: signed adjugate entry over determinant magnitude,
// pipelined restoring division with saturation. Depends on mi3_pkg.
module mi3_lane #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic signed [2*ELEM_WIDTH:0]  adj,
    input  logic [3*ELEM_WIDTH+1:0]       dmag,
    input  logic                          dneg,
    output logic signed [ELEM_WIDTH-1:0]  q,
    output logic                          sat
);
    import mi3_pkg::*;

    localparam int EW = ELEM_WIDTH;
    localparam int AW = 2 * EW + 1;
    localparam int DW = 3 * EW + 2;
    localparam int RW = DW + EW + 2 * FRAC_BITS;
    localparam logic [EW-1:0] LIM    = {1'b1, {(EW-1){1'b0}}};
    localparam logic [EW-1:0] LIM_M1 = ~LIM;

    logic [AW-1:0] mag;
    logic [RW-1:0] num_reg;
    logic [RW-1:0] d_reg;
    logic          neg_reg;

    logic [RW-1:0] rem_reg [EW+1];
    logic [RW-1:0] dd_reg  [EW+1];
    logic [EW-1:0] qq_reg  [EW+1];
    logic          ng_reg  [EW+1];
    logic          bg_reg  [EW+1];

    logic signed [EW-1:0] q_reg;
    logic                 sat_reg;
    logic signed [EW-1:0] q_next;
    logic                 sat_next;

    // Magnitude of the numerator, scaled by two fraction widths.
    assign mag = adj[AW-1] ? AW'(-adj) : AW'(adj);

    always_ff @(posedge clk)
    begin
        num_reg <= RW'(mag) << (2 * FRAC_BITS);
        d_reg   <= RW'(dmag);
        neg_reg <= adj[AW-1] ^ dneg;
    end

    // Overflow check: a quotient of 2^EW or more only saturates.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_reg;
        dd_reg[0]  <= d_reg;
        qq_reg[0]  <= '0;
        ng_reg[0]  <= neg_reg;
        bg_reg[0]  <= (num_reg >= (d_reg << EW));
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < EW; s++)
    begin : g_div
        localparam int SH = EW - 1 - s;
        logic [RW:0] trial;
        logic        take;

        assign trial = {1'b0, rem_reg[s]} - {1'b0, dd_reg[s] << SH};
        assign take  = !trial[RW];

        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= take ? trial[RW-1:0] : rem_reg[s];
            qq_reg[s+1]  <= qq_reg[s] | (take ? (EW'(1) << SH) : '0);
            dd_reg[s+1]  <= dd_reg[s];
            ng_reg[s+1]  <= ng_reg[s];
            bg_reg[s+1]  <= bg_reg[s];
        end
    end

    // Apply the sign and clamp to the signed output range.
    always_comb
    begin
        sat_next = 1'b0;
        if (ng_reg[EW])
        begin
            if (bg_reg[EW] || (qq_reg[EW] > LIM))
            begin
                sat_next = 1'b1;
                q_next   = LIM;
            end
            else
            begin
                q_next = -qq_reg[EW];
            end
        end
        else
        begin
            if (bg_reg[EW] || (qq_reg[EW] > LIM_M1))
            begin
                sat_next = 1'b1;
                q_next   = LIM_M1;
            end
            else
            begin
                q_next = qq_reg[EW];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign q   = q_reg;
    assign sat = sat_reg;

endmodule

@@ hw/rtl/matrix3_inverse_adjugate.sv @@
// 3x3 matrix inverse by the adjugate: one matrix in, its inverse out.
// A new matrix is taken on every clock cycle with start high; busy stays low. Each
// result appears on the output ports for one cycle with done high, in order; the
// receiver must take it then. The nine divider lanes each resolve one quotient bit
// per stage. Singular matrices return zeros with status singular; out-of-range
// quotients clamp.
// Depends on mi3_pkg, mi3_adj, mi3_lane and matrix3_inverse_adjugate_macros.svh.
module matrix3_inverse_adjugate #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c2,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c2,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c2,
    output logic                         done,
    output logic signed [ELEM_WIDTH-1:0] out_r0c0,
    output logic signed [ELEM_WIDTH-1:0] out_r1c0,
    output logic signed [ELEM_WIDTH-1:0] out_r2c0,
    output logic signed [ELEM_WIDTH-1:0] out_r0c1,
    output logic signed [ELEM_WIDTH-1:0] out_r1c1,
    output logic signed [ELEM_WIDTH-1:0] out_r2c1,
    output logic signed [ELEM_WIDTH-1:0] out_r0c2,
    output logic signed [ELEM_WIDTH-1:0] out_r1c2,
    output logic signed [ELEM_WIDTH-1:0] out_r2c2,
    output mi3_pkg::status_t             inv_status
);
    import mi3_pkg::*;

    `include "matrix3_inverse_adjugate_macros.svh"

    localparam int EW   = ELEM_WIDTH;
    localparam int AW   = 2 * EW + 1;
    localparam int DW   = 3 * EW + 2;
    localparam int SLAT = EW + 3;
    localparam int LAT  = EW + 8;

    logic signed [EW-1:0] m     [NUM_ELEM];
    logic signed [AW-1:0] adj   [NUM_ELEM];
    logic signed [DW-1:0] det;
    logic [DW-1:0]        dmag;
    logic                 dneg;
    logic signed [EW-1:0] lane_q   [NUM_ELEM];
    logic [NUM_ELEM-1:0]  lane_sat;

    logic [LAT-1:0]       vld_reg;
    logic [SLAT-1:0]      sing_reg;
    logic signed [EW-1:0] out_reg [NUM_ELEM];
    status_t              status_reg;

    assign busy = 1'b0;

    // Column-major element vector.
    assign m[0] = in_r0c0;
    assign m[1] = in_r1c0;
    assign m[2] = in_r2c0;
    assign m[3] = in_r0c1;
    assign m[4] = in_r1c1;
    assign m[5] = in_r2c1;
    assign m[6] = in_r0c2;
    assign m[7] = in_r1c2;
    assign m[8] = in_r2c2;

    // Adjugate and determinant.
    mi3_adj #(
        .ELEM_WIDTH (EW)
    ) u_adj (
        .clk (clk),
        .m   (m),
        .adj (adj),
        .det (det)
    );

    // Determinant sign and magnitude, shared by all lanes.
    assign dneg = det[DW-1];
    assign dmag = dneg ? DW'(-det) : DW'(det);

    // Nine divider lanes, one per inverse element.
    for (genvar k = 0; k < NUM_ELEM; k++)
    begin : g_lane
        mi3_lane #(
            .ELEM_WIDTH (EW),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .adj  (adj[k]),
            .dmag (dmag),
            .dneg (dneg),
            .q    (lane_q[k]),
            .sat  (lane_sat[k])
        );
    end

    // Item tracking along the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    // Singular flag follows the item through the lane latency.
    always_ff @(posedge clk)
    begin
        sing_reg <= {sing_reg[SLAT-2:0], (det == '0)};
    end

    // Merge lane results and status.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            out_reg[k] <= sing_reg[SLAT-1] ? '0 : lane_q[k];
        end
        if (sing_reg[SLAT-1])
        begin
            status_reg <= ST_SINGULAR;
        end
        else if (|lane_sat)
        begin
            status_reg <= ST_SATURATED;
        end
        else
        begin
            status_reg <= ST_OK;
        end
    end

    assign done       = vld_reg[LAT-1];
    assign inv_status = status_reg;
    assign out_r0c0   = out_reg[0];
    assign out_r1c0   = out_reg[1];
    assign out_r2c0   = out_reg[2];
    assign out_r0c1   = out_reg[3];
    assign out_r1c1   = out_reg[4];
    assign out_r2c1   = out_reg[5];
    assign out_r0c2   = out_reg[6];
    assign out_r1c2   = out_reg[7];
    assign out_r2c2   = out_reg[8];

    // A singular result carries an all-zero matrix.
    `MI3_ASSERT_IMP(a_sing_zero, done && (inv_status == ST_SINGULAR), (out_r0c0 == '0) && (out_r1c1 == '0) && (out_r2c2 == '0) && (out_r0c2 == '0), "singular result with nonzero elements")
    // Only defined status codes leave the block.
    `MI3_ASSERT_IMP(a_status_code, done, (inv_status == ST_OK) || (inv_status == ST_SINGULAR) || (inv_status == ST_SATURATED), "undefined status code")
    // An accepted item is registered into the valid tracking chain.
    `MI3_ASSERT_NXT(a_lat_track, start, vld_reg[0], "accepted item not tracked")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the 3x3 matrix inverse block matrix3_inverse_adjugate.
// Holds its own exact-integer predictor and drives directed and random matrices.
// Depends on mi3_pkg and the RTL of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mi3_pkg::*;

    localparam int EW         = 32;
    localparam int FB         = 16;
    localparam int WATCHDOG   = 2000;
    localparam int DRAIN      = EW + 20;
    localparam logic signed [EW-1:0] ONE = 32'sh0001_0000;

    typedef logic signed [EW-1:0]  elem_t;
    typedef logic signed [159:0]   wide_t;
    typedef elem_t                 matrix_t [NUM_ELEM];

    typedef struct {
        elem_t   elem [NUM_ELEM];
        status_t status;
    } inverse_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    done;
    elem_t   in_m  [NUM_ELEM];
    elem_t   out_m [NUM_ELEM];
    status_t inv_status;

    inverse_t expected_inverses [$];
    int       accept_count;
    int       error_count;
    int       idle_pct;
    int       quiet_cycles;

    string elem_name [NUM_ELEM] = '{"r0c0", "r1c0", "r2c0", "r0c1", "r1c1", "r2c1",
                                    "r0c2", "r1c2", "r2c2"};

    matrix3_inverse_adjugate #(
        .ELEM_WIDTH (EW),
        .FRAC_BITS  (FB)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .in_r0c0    (in_m[0]),
        .in_r1c0    (in_m[1]),
        .in_r2c0    (in_m[2]),
        .in_r0c1    (in_m[3]),
        .in_r1c1    (in_m[4]),
        .in_r2c1    (in_m[5]),
        .in_r0c2    (in_m[6]),
        .in_r1c2    (in_m[7]),
        .in_r2c2    (in_m[8]),
        .done       (done),
        .out_r0c0   (out_m[0]),
        .out_r1c0   (out_m[1]),
        .out_r2c0   (out_m[2]),
        .out_r0c1   (out_m[3]),
        .out_r1c1   (out_m[4]),
        .out_r2c1   (out_m[5]),
        .out_r0c2   (out_m[6]),
        .out_r1c2   (out_m[7]),
        .out_r2c2   (out_m[8]),
        .inv_status (inv_status)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Exact inverse: adjugate over determinant, truncated toward zero and clamped.
    function automatic inverse_t invert_matrix(input elem_t m [NUM_ELEM]);
        wide_t    mw  [NUM_ELEM];
        wide_t    adj [NUM_ELEM];
        wide_t    det;
        wide_t    quo;
        wide_t    hi_lim;
        wide_t    lo_lim;
        inverse_t r;
        bit       sat;
        hi_lim = (wide_t'(1) <<< (EW - 1)) - 1;
        lo_lim = -(wide_t'(1) <<< (EW - 1));
        sat = 1'b0;
        for (int i = 0; i < NUM_ELEM; i++)
            mw[i] = m[i];
        for (int k = 0; k < NUM_ELEM; k++)
            adj[k] = mw[COF_A[k]] * mw[COF_B[k]] - mw[COF_C[k]] * mw[COF_D[k]];
        det = mw[0] * adj[0] + mw[3] * adj[1] + mw[6] * adj[2];
        if (det == 0)
        begin
            for (int i = 0; i < NUM_ELEM; i++)
                r.elem[i] = '0;
            r.status = ST_SINGULAR;
            return r;
        end
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            quo = (adj[i] <<< (2 * FB)) / det;
            if (quo > hi_lim)
            begin
                quo = hi_lim;
                sat = 1'b1;
            end
            else if (quo < lo_lim)
            begin
                quo = lo_lim;
                sat = 1'b1;
            end
            r.elem[i] = quo[EW-1:0];
        end
        r.status = sat ? ST_SATURATED : ST_OK;
        return r;
    endfunction

    // Accepted items are predicted; each strobed result is checked against the oldest.
    always @(posedge clk)
    begin
        inverse_t exp_inv;
        if (rst_n && start && !busy)
        begin
            expected_inverses.push_back(invert_matrix(in_m));
            accept_count++;
        end
        if (rst_n && done)
        begin
            if (expected_inverses.size() == 0)
            begin
                $error("result with no matrix outstanding");
                error_count++;
            end
            else
            begin
                exp_inv = expected_inverses.pop_front();
                for (int i = 0; i < NUM_ELEM; i++)
                    if (out_m[i] !== exp_inv.elem[i])
                    begin
                        $error("out_%s: expected %h, got %h", elem_name[i],
                               exp_inv.elem[i], out_m[i]);
                        error_count++;
                    end
                if (inv_status !== exp_inv.status)
                begin
                    $error("inv_status: expected %0d, got %0d", exp_inv.status, inv_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with neither an accepted item nor a result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("** matrix3_inverse_adjugate: FAILED **");
            $finish;
        end
    end

    // Send one item after a random gap; returns at the falling edge after acceptance.
    task automatic send_matrix(input elem_t m [NUM_ELEM]);
        int n;
        if (($urandom_range(99) < idle_pct))
        begin
            start = 1'b0;
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
            @(negedge clk);
        end
        in_m  = m;
        start = 1'b1;
        n = accept_count;
        do
            @(negedge clk);
        while (accept_count == n);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain_results();
        start = 1'b0;
        while (expected_inverses.size() != 0)
            @(negedge clk);
    endtask

    function automatic matrix_t diag_matrix(input elem_t a, input elem_t b, input elem_t c);
        matrix_t m;
        m = '{default: '0};
        m[0] = a;
        m[4] = b;
        m[8] = c;
        return m;
    endfunction

    // Directed corners: identity, zeros, extremes, singular and saturating cases.
    task automatic test_directed();
        matrix_t m;
        idle_pct = 0;
        send_matrix(diag_matrix(ONE, ONE, ONE));
        send_matrix(diag_matrix(2 * ONE, -ONE, ONE / 2));
        send_matrix(diag_matrix(-ONE, -ONE, -ONE));
        send_matrix(diag_matrix(1, 1, 1));
        send_matrix(diag_matrix(ONE, ONE, 1));
        send_matrix(diag_matrix(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
        send_matrix(diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        send_matrix(diag_matrix(32'sh8000_0000, ONE, ONE));
        send_matrix(diag_matrix(ONE / 2, ONE, ONE));
        send_matrix('{default: '0});
        send_matrix('{default: 32'sh7fff_ffff});
        send_matrix('{default: 32'sh8000_0000});
        send_matrix('{default: -1});
        // Permutation matrix with negative determinant.
        m = '{default: '0};
        m[1] = ONE;
        m[3] = ONE;
        m[8] = ONE;
        send_matrix(m);
        // Two equal columns make the determinant zero.
        m = '{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 5, -7, 32'sh7fff_ffff};
        send_matrix(m);
        // Upper triangular with mixed extremes.
        m = '{ONE, 0, 0, 32'sh8000_0000, ONE, 0, 32'sh7fff_ffff, -ONE, ONE};
        send_matrix(m);
        m = '{3 * ONE, ONE, 0, -ONE, 2 * ONE, ONE, 0, -ONE, 4 * ONE};
        send_matrix(m);
        start = 1'b0;
        drain_results();
    endtask

    function automatic matrix_t random_matrix();
        matrix_t m;
        int      kind;
        kind = $urandom_range(9);
        for (int i = 0; i < NUM_ELEM; i++)
            case (kind)
                0, 1:    m[i] = $urandom;
                2:       m[i] = $urandom_range(3) == 0 ?
                                ($urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000) :
                                $urandom;
                default: m[i] = $signed($urandom_range(8 * ONE)) - 4 * ONE;
            endcase
        // Some matrices are made singular by a repeated or scaled-zero column.
        if ($urandom_range(7) == 0)
            for (int i = 0; i < 3; i++)
                m[6 + i] = (kind == 3) ? '0 : m[i];
        return m;
    endfunction

    // Random matrices at a given sender idle rate.
    task automatic test_random(input int count, input int pct);
        idle_pct = pct;
        for (int n = 0; n < count; n++)
        begin
            send_matrix(random_matrix());
            if (n == count / 2 && pct == 70)
                drain_results();
        end
        start = 1'b0;
    endtask

    // Test sequence.
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        in_m         = '{default: '0};
        accept_count = 0;
        error_count  = 0;
        idle_pct     = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(400, 0);
        test_random(300, 70);
        test_random(300, 26);
        test_random(350, 0);

        drain_results();
        repeat (DRAIN) @(negedge clk);
        if (expected_inverses.size() != 0)
        begin
            $error("%0d results never arrived", expected_inverses.size());
            error_count++;
        end
        if (error_count == 0)
            $display("** matrix3_inverse_adjugate: PASSED **");
        else
            $display("** matrix3_inverse_adjugate: FAILED **");
        $finish;
    end

endmodule
